[hw/rtl/lrrp_pkg.sv]
//------------------------------------------------------------------------------
// lrrp_pkg
// Types and constants shared by the raster record parser modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrrp_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_WAVEFORMS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_CLEAN_INDEX = 2'd2;

    localparam logic [7:0]  RASTER_TYPE    = 8'd5;
    localparam logic [23:0] MIN_RASTER_LEN = 24'd18;
    localparam logic [23:0] PULSE_HDR_LEN  = 24'd15;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_WAVE  = 1'b1;

    typedef enum logic [10:0] {
        PH_LEN    = 11'b000_0000_0001,
        PH_HDR    = 11'b000_0000_0010,
        PH_SKIP   = 11'b000_0000_0100,
        PH_PULSE  = 11'b000_0000_1000,
        PH_TXLEN  = 11'b000_0001_0000,
        PH_TX     = 11'b000_0010_0000,
        PH_RXLEN0 = 11'b000_0100_0000,
        PH_RXLEN1 = 11'b000_1000_0000,
        PH_RX     = 11'b001_0000_0000,
        PH_PAD    = 11'b010_0000_0000,
        PH_HALT   = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_log;
    } t_in_word;

    typedef struct packed {
        logic               kind;
        logic [31:0]        raster_number;
        logic [14:0]        pulse_number;
        logic               digitizer;
        logic [31:0]        seconds;
        logic [32:0]        time_ticks;
        logic signed [15:0] beam_angle;
        logic [13:0]        range_value;
        logic [1:0]         dropout;
        logic [2:0]         channel;
        logic [15:0]        sample_index;
        logic [7:0]         sample_value;
    } t_out_word;

    typedef struct packed {
        logic [31:0] raster_start;
        logic        emit_waveforms;
        logic [7:0]  tx_clean_index;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/lrrp_core.sv]
//------------------------------------------------------------------------------
// lrrp_core
// Parser state and the per-byte step: record framing, raster header,
// pulse headers and waveform bytes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrrp_core #(
    parameter int RX_CHANNELS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire lrrp_pkg::t_in_word i_item,
    input  wire lrrp_pkg::t_cfg     i_cfg,
    input  wire logic               i_rs_load,
    input  wire logic [31:0]        i_rs_value,
    output logic                    o_res_valid,
    output lrrp_pkg::t_out_word     o_res
);

    import lrrp_pkg::*;

    localparam int RC_W = $clog2(RX_CHANNELS + 1);
    localparam logic [RC_W-1:0] RC_MAX = RC_W'(RX_CHANNELS);

    t_phase          r_phase, n_phase;
    logic [23:0]     r_record_position, n_record_position;
    logic [23:0]     r_record_length, n_record_length;
    logic [7:0]      r_field_shift, n_field_shift;
    logic [31:0]     r_header_seconds, n_header_seconds;
    logic [31:0]     r_header_fraction, n_header_fraction;
    logic [14:0]     r_pulses_left, n_pulses_left;
    logic [14:0]     r_pulse_counter, n_pulse_counter;
    logic [23:0]     r_pulse_end, n_pulse_end;
    logic [15:0]     r_wave_remaining, n_wave_remaining;
    logic [RC_W-1:0] r_receive_channel, n_receive_channel;
    logic [7:0]      r_first_tx_byte, n_first_tx_byte;
    logic [31:0]     r_raster_counter, n_raster_counter;
    logic            r_is_raster, n_is_raster;
    logic            r_digit_bit, n_digit_bit;
    logic [23:0]     r_pulse_start, n_pulse_start;
    logic [23:0]     r_pulse_ticks, n_pulse_ticks;
    logic [15:0]     r_pulse_angle, n_pulse_angle;
    logic [15:0]     r_pulse_word, n_pulse_word;
    logic [15:0]     r_pulse_len, n_pulse_len;
    logic [15:0]     r_wave_index, n_wave_index;

    logic [7:0]  b;
    logic [23:0] pos;
    logic [23:0] rel;
    logic [15:0] plen_new;
    logic [25:0] pend_raw;
    logic [23:0] pend_clamp;
    logic [15:0] rxlen;
    logic [24:0] rx_end;
    logic [7:0]  ftb;
    logic        clean_hit;
    logic [15:0] wr_dec;
    t_phase      aw_phase;
    logic        check_end;
    logic        rec_done;
    logic        sp_req;
    logic [24:0] sp_start;
    logic [14:0] sp_left;
    logic [14:0] sp_counter;
    logic        sp_ok;
    logic [14:0] hdr_count;

    assign b          = i_item.data_byte;
    assign pos        = r_record_position;
    assign rel        = pos - r_pulse_start;
    assign plen_new   = r_pulse_len | {b, 8'h00};
    assign pend_raw   = 26'(r_pulse_start) + 26'd14 + 26'(plen_new);
    assign pend_clamp = (pend_raw >= 26'(r_record_length)) ? (r_record_length - 24'd1)
                                                           : pend_raw[23:0];
    assign rxlen      = {b, r_field_shift};
    assign rx_end     = 25'(pos) + 25'(rxlen);
    assign ftb        = (r_wave_index == 16'd0) ? b : r_first_tx_byte;
    assign clean_hit  = (i_cfg.tx_clean_index != 8'd0) &&
                        (r_wave_index >= (16'(i_cfg.tx_clean_index) - 16'd1));
    assign wr_dec     = r_wave_remaining - 16'd1;
    assign aw_phase   = (r_receive_channel < RC_MAX) ? PH_RXLEN0 : PH_PAD;
    assign hdr_count  = {b[6:0], r_field_shift};
    assign sp_ok      = (sp_left != 15'd0) &&
                        ((26'(sp_start) + 26'(PULSE_HDR_LEN) + 26'd1) <= 26'(r_record_length));

    always_comb begin
        n_phase           = r_phase;
        n_record_position = r_record_position;
        n_record_length   = r_record_length;
        n_field_shift     = r_field_shift;
        n_header_seconds  = r_header_seconds;
        n_header_fraction = r_header_fraction;
        n_pulses_left     = r_pulses_left;
        n_pulse_counter   = r_pulse_counter;
        n_pulse_end       = r_pulse_end;
        n_wave_remaining  = r_wave_remaining;
        n_receive_channel = r_receive_channel;
        n_first_tx_byte   = r_first_tx_byte;
        n_raster_counter  = r_raster_counter;
        n_is_raster       = r_is_raster;
        n_digit_bit       = r_digit_bit;
        n_pulse_start     = r_pulse_start;
        n_pulse_ticks     = r_pulse_ticks;
        n_pulse_angle     = r_pulse_angle;
        n_pulse_word      = r_pulse_word;
        n_pulse_len       = r_pulse_len;
        n_wave_index      = r_wave_index;
        check_end         = 1'b0;
        rec_done          = 1'b0;
        sp_req            = 1'b0;
        sp_start          = 25'(pos) + 25'd1;
        sp_left           = r_pulses_left;
        sp_counter        = r_pulse_counter;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_PULSE;
        o_res.raster_number  = r_raster_counter;
        o_res.pulse_number   = r_pulse_counter;
        o_res.digitizer      = r_digit_bit;
        o_res.seconds        = r_header_seconds;
        o_res.time_ticks     = 33'(r_header_fraction) + 33'(r_pulse_ticks);
        o_res.beam_angle     = $signed(r_pulse_angle);
        o_res.range_value    = r_pulse_word[13:0];
        o_res.dropout        = r_pulse_word[15:14];
        o_res.channel        = 3'd0;
        o_res.sample_index   = 16'd0;
        o_res.sample_value   = 8'd0;

        case (r_phase)
            PH_LEN: begin
                case (pos[1:0])
                    2'd0:    n_record_length = {16'h0000, b};
                    2'd1:    n_record_length = r_record_length | {8'h00, b, 8'h00};
                    default: n_record_length = r_record_length | {b, 16'h0000};
                endcase
                if (pos >= 24'd2) begin
                    n_is_raster = 1'b0;
                    if (n_record_length == 24'd0) begin
                        n_phase = PH_HALT;
                    end else if (n_record_length <= 24'd3) begin
                        rec_done = 1'b1;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                case (pos)
                    24'd3: begin
                        n_is_raster = (r_record_length >= MIN_RASTER_LEN) && (b == RASTER_TYPE);
                        if (!n_is_raster) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    24'd4:  n_header_seconds  = {24'h0, b};
                    24'd5:  n_header_seconds  = r_header_seconds | {16'h0, b, 8'h0};
                    24'd6:  n_header_seconds  = r_header_seconds | {8'h0, b, 16'h0};
                    24'd7:  n_header_seconds  = r_header_seconds | {b, 24'h0};
                    24'd8:  n_header_fraction = {24'h0, b};
                    24'd9:  n_header_fraction = r_header_fraction | {16'h0, b, 8'h0};
                    24'd10: n_header_fraction = r_header_fraction | {8'h0, b, 16'h0};
                    24'd11: n_header_fraction = r_header_fraction | {b, 24'h0};
                    24'd16: n_field_shift     = b;
                    24'd17: begin
                        n_pulses_left   = hdr_count;
                        n_pulse_counter = 15'd0;
                        n_digit_bit     = b[7];
                        sp_left         = hdr_count;
                        sp_counter      = 15'd0;
                        sp_start        = 25'(MIN_RASTER_LEN);
                        sp_req          = 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_PULSE: begin
                if (rel == 24'd0) begin
                    n_pulse_ticks = {16'h0, b};
                end else if (rel == 24'd1) begin
                    n_pulse_ticks = r_pulse_ticks | {8'h0, b, 8'h0};
                end else if (rel == 24'd2) begin
                    n_pulse_ticks = r_pulse_ticks | {b, 16'h0};
                end else if (rel == 24'd9) begin
                    n_pulse_angle = {8'h0, b};
                end else if (rel == 24'd10) begin
                    n_pulse_angle = r_pulse_angle | {b, 8'h0};
                end else if (rel == 24'd11) begin
                    n_pulse_word = {8'h0, b};
                end else if (rel == 24'd12) begin
                    n_pulse_word = r_pulse_word | {b, 8'h0};
                end else if (rel == 24'd13) begin
                    n_pulse_len = {8'h0, b};
                end else if (rel >= 24'd14) begin
                    n_pulse_len       = plen_new;
                    n_pulse_end       = pend_clamp;
                    o_res_valid       = 1'b1;
                    n_receive_channel = '0;
                    if (i_cfg.emit_waveforms &&
                        ((25'(r_pulse_start) + 25'(PULSE_HDR_LEN)) <= 25'(pend_clamp))) begin
                        n_phase = PH_TXLEN;
                    end else begin
                        n_phase = PH_PAD;
                    end
                    check_end = 1'b1;
                end
            end
            PH_TXLEN: begin
                n_wave_remaining = {8'h00, b};
                n_wave_index     = 16'd0;
                n_phase          = (b != 8'd0) ? PH_TX : PH_PAD;
                check_end        = 1'b1;
            end
            PH_TX: begin
                n_first_tx_byte    = ftb;
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_WAVE;
                o_res.sample_index = r_wave_index;
                o_res.sample_value = clean_hit ? ftb : b;
                n_wave_index       = r_wave_index + 16'd1;
                n_wave_remaining   = wr_dec;
                if (wr_dec == 16'd0) begin
                    n_phase = aw_phase;
                end
                check_end = 1'b1;
            end
            PH_RXLEN0: begin
                n_field_shift = b;
                n_phase       = PH_RXLEN1;
                check_end     = 1'b1;
            end
            PH_RXLEN1: begin
                if ((rxlen == 16'd0) || (rx_end > 25'(r_pulse_end))) begin
                    n_phase = PH_PAD;
                end else begin
                    n_receive_channel = r_receive_channel + RC_W'(1);
                    n_wave_remaining  = rxlen;
                    n_wave_index      = 16'd0;
                    n_phase           = PH_RX;
                end
                check_end = 1'b1;
            end
            PH_RX: begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_WAVE;
                o_res.channel      = 3'(r_receive_channel);
                o_res.sample_index = r_wave_index;
                o_res.sample_value = b;
                n_wave_index       = r_wave_index + 16'd1;
                n_wave_remaining   = wr_dec;
                if (wr_dec == 16'd0) begin
                    n_phase = aw_phase;
                end
                check_end = 1'b1;
            end
            PH_PAD: begin
                check_end = 1'b1;
            end
            default: ;
        endcase

        // pulse finished on this byte: try the next pulse header
        if (check_end && (pos == n_pulse_end)) begin
            sp_req = 1'b1;
        end

        if (sp_req) begin
            if (sp_ok) begin
                n_pulse_start   = sp_start[23:0];
                n_pulses_left   = sp_left - 15'd1;
                n_pulse_counter = sp_counter + 15'd1;
                n_phase         = PH_PULSE;
            end else begin
                n_phase = PH_SKIP;
            end
        end

        if ((n_phase != PH_LEN) && (n_phase != PH_HALT) &&
            ((25'(pos) + 25'd1) == 25'(n_record_length))) begin
            rec_done = 1'b1;
        end

        if (rec_done) begin
            if (n_is_raster && (r_raster_counter != 32'd0)) begin
                n_raster_counter = r_raster_counter + 32'd1;
            end
            n_is_raster       = 1'b0;
            n_phase           = PH_LEN;
            n_record_position = 24'd0;
        end else if (n_phase != PH_HALT) begin
            n_record_position = pos + 24'd1;
        end

        if (i_item.end_of_log) begin
            n_phase           = PH_LEN;
            n_record_position = 24'd0;
            n_record_length   = 24'd0;
            n_is_raster       = 1'b0;
            n_raster_counter  = i_cfg.raster_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_LEN;
            r_record_position <= '0;
            r_record_length   <= '0;
            r_field_shift     <= '0;
            r_header_seconds  <= '0;
            r_header_fraction <= '0;
            r_pulses_left     <= '0;
            r_pulse_counter   <= '0;
            r_pulse_end       <= '0;
            r_wave_remaining  <= '0;
            r_receive_channel <= '0;
            r_first_tx_byte   <= '0;
            r_raster_counter  <= '0;
            r_is_raster       <= 1'b0;
            r_digit_bit       <= 1'b0;
            r_pulse_start     <= '0;
            r_pulse_ticks     <= '0;
            r_pulse_angle     <= '0;
            r_pulse_word      <= '0;
            r_pulse_len       <= '0;
            r_wave_index      <= '0;
        end else begin
            if (i_step) begin
                r_phase           <= n_phase;
                r_record_position <= n_record_position;
                r_record_length   <= n_record_length;
                r_field_shift     <= n_field_shift;
                r_header_seconds  <= n_header_seconds;
                r_header_fraction <= n_header_fraction;
                r_pulses_left     <= n_pulses_left;
                r_pulse_counter   <= n_pulse_counter;
                r_pulse_end       <= n_pulse_end;
                r_wave_remaining  <= n_wave_remaining;
                r_receive_channel <= n_receive_channel;
                r_first_tx_byte   <= n_first_tx_byte;
                r_is_raster       <= n_is_raster;
                r_digit_bit       <= n_digit_bit;
                r_pulse_start     <= n_pulse_start;
                r_pulse_ticks     <= n_pulse_ticks;
                r_pulse_angle     <= n_pulse_angle;
                r_pulse_word      <= n_pulse_word;
                r_pulse_len       <= n_pulse_len;
                r_wave_index      <= n_wave_index;
            end
            if (i_rs_load) begin
                r_raster_counter <= i_rs_value;
            end else if (i_step) begin
                r_raster_counter <= n_raster_counter;
            end
        end
    end

`ifndef SYNTHESIS
    a_pulse_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PULSE) |->
            ((26'(r_pulse_start) + 26'(PULSE_HDR_LEN) + 26'd1) <= 26'(r_record_length)))
        else $error("pulse header runs past record end");

    a_rx_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_receive_channel <= RC_MAX)
        else $error("receive channel out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.end_of_log) |=>
            ((r_phase == PH_LEN) && (r_record_position == 24'd0) && !r_is_raster))
        else $error("end of log did not restart parser");

    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_HALT) && i_step && !i_item.end_of_log) |=>
            ((r_phase == PH_HALT) && $stable(r_record_position)))
        else $error("halted parser moved");
`endif

endmodule

`default_nettype wire

[hw/rtl/lidar_raster_record_parser.sv]
//------------------------------------------------------------------------------
// lidar_raster_record_parser
// Byte-stream parser for raw lidar raster logs; emits pulse and waveform words.
//------------------------------------------------------------------------------
// Takes one log byte per cycle and gives at most one result word per byte.
// A byte is held in the input register, is parsed against the
// record state, and its result lands in the output register;
// one byte per cycle is sustained while the output side takes words.
// Only a full output register that is not being taken stalls the input.
// Time is reported as raster seconds plus 1.6 us ticks. No clearing pass is
// needed after reset. Configuration registers: 0 raster_start (also reloads
// the raster counter), 1 emit_waveforms, 2 tx_clean_index.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_raster_record_parser #(
    parameter int RX_CHANNELS = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire lrrp_pkg::t_in_word               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output lrrp_pkg::t_out_word                   o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lrrp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                      i_cfg_data
);

    import lrrp_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_cfg      r_cfg;

    logic      out_free;
    logic      step;
    logic      rs_load;
    logic      res_valid;
    t_out_word res;

    assign out_free    = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;
    assign o_cfg_ready = 1'b1;
    assign rs_load     = i_cfg_valid && (i_cfg_index == CFG_RASTER_START);

    lrrp_core #(
        .RX_CHANNELS (RX_CHANNELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_word),
        .i_cfg       (r_cfg),
        .i_rs_load   (rs_load),
        .i_rs_value  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RASTER_START:   r_cfg.raster_start   <= i_cfg_data;
                    CFG_EMIT_WAVEFORMS: r_cfg.emit_waveforms <= i_cfg_data[0];
                    CFG_TX_CLEAN_INDEX: r_cfg.tx_clean_index <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_data;
        end
        if (step && res_valid) begin
            r_out_word <= res;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar raster record parser.
//------------------------------------------------------------------------------
// Feeds byte streams into the parser and checks every word that comes out.
// A few hand-built framing cases come first. After that, random logs are
// built from raster records with random content and random pulses and
// waveforms. Lengths and counts are sometimes corrupted, other record types
// are mixed in, logs are sometimes halted or cut short, and some logs are
// plain noise. The run steps through several register settings, the
// extremes among them, with random sender gaps and receiver stalls. A
// scoreboard class tracks the parser state byte by byte and checks each
// output word, in order, against the word it should be.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

import lrrp_pkg::*;

class record_parser_scoreboard #(int RX_CH = 4);
    logic [31:0] raster_start;
    logic        emit_waves;
    logic [7:0]  clean_idx;

    t_phase      phase;
    logic [23:0] rec_pos;
    logic [23:0] rec_len;
    logic [7:0]  low_byte;
    logic [31:0] hdr_sec;
    logic [31:0] hdr_frac;
    logic [14:0] pulses_left;
    logic [14:0] pulse_cnt;
    logic [23:0] pulse_start;
    logic [23:0] pulse_end;
    logic [15:0] wave_left;
    logic [15:0] wave_idx;
    logic [2:0]  rx_chan;
    logic [7:0]  first_tx;
    logic [31:0] raster_cnt;
    logic        in_raster;
    logic        digit;
    logic [23:0] ticks;
    logic [15:0] angle;
    logic [15:0] pword;
    logic [15:0] plen;

    t_out_word   parsed_words[$];
    int          fails;
    int          checked;
    int          n_pulse;
    int          n_wave;
    int          n_raster;

    function new();
        raster_start = '0;
        emit_waves   = 1'b0;
        clean_idx    = '0;
        low_byte     = '0;
        hdr_sec      = '0;
        hdr_frac     = '0;
        pulses_left  = '0;
        pulse_cnt    = '0;
        pulse_start  = '0;
        pulse_end    = '0;
        wave_left    = '0;
        wave_idx     = '0;
        rx_chan      = '0;
        first_tx     = '0;
        digit        = 1'b0;
        ticks        = '0;
        angle        = '0;
        pword        = '0;
        plen         = '0;
        fails        = 0;
        checked      = 0;
        n_pulse      = 0;
        n_wave       = 0;
        n_raster     = 0;
        restart();
    endfunction

    function void restart();
        phase      = PH_LEN;
        rec_pos    = '0;
        rec_len    = '0;
        in_raster  = 1'b0;
        raster_cnt = raster_start;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_RASTER_START: begin
                raster_start = data;
                raster_cnt   = data;
            end
            CFG_EMIT_WAVEFORMS: emit_waves = data[0];
            CFG_TX_CLEAN_INDEX: clean_idx = data[7:0];
            default: ;
        endcase
    endfunction

    function void push_word(logic kind, logic [2:0] ch, logic [15:0] idx, logic [7:0] val);
        t_out_word w;
        w.kind          = kind;
        w.raster_number = raster_cnt;
        w.pulse_number  = pulse_cnt;
        w.digitizer     = digit;
        w.seconds       = hdr_sec;
        w.time_ticks    = {1'b0, hdr_frac} + {9'd0, ticks};
        w.beam_angle    = angle;
        w.range_value   = pword[13:0];
        w.dropout       = pword[15:14];
        w.channel       = ch;
        w.sample_index  = idx;
        w.sample_value  = val;
        parsed_words.push_back(w);
        if (kind == KIND_PULSE) begin
            n_pulse++;
        end else begin
            n_wave++;
        end
    endfunction

    function void start_pulse(int unsigned s);
        if (pulses_left == 0 || longint'(s) + PULSE_HDR_LEN > longint'(rec_len) - 1) begin
            phase = PH_SKIP;
        end else begin
            pulse_start = s[23:0];
            pulses_left = pulses_left - 1'b1;
            pulse_cnt   = pulse_cnt + 1'b1;
            phase       = PH_PULSE;
        end
    endfunction

    function void next_wave();
        phase = (rx_chan < RX_CH) ? PH_RXLEN0 : PH_PAD;
    endfunction

    function void parse_byte(t_in_word w);
        logic [7:0]  b;
        logic [23:0] pos;
        logic [15:0] len16;
        logic [7:0]  v;
        logic        rec_done;
        logic        check_end;
        int unsigned rel;
        longint      e;
        b         = w.data_byte;
        pos       = rec_pos;
        rec_done  = 1'b0;
        check_end = 1'b0;

        case (phase)
            PH_LEN: begin
                if (pos == 0) begin
                    rec_len = {16'h0, b};
                end else if (pos[1:0] == 2'd1) begin
                    rec_len = rec_len | {8'h0, b, 8'h0};
                end else if (pos[1:0] == 2'd2) begin
                    rec_len = rec_len | {b, 16'h0};
                end
                if (pos >= 2) begin
                    in_raster = 1'b0;
                    if (rec_len == 0) begin
                        phase = PH_HALT;
                    end else if (rec_len <= 3) begin
                        rec_done = 1'b1;
                    end else begin
                        phase = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                if (pos == 3) begin
                    in_raster = (rec_len >= MIN_RASTER_LEN && b == RASTER_TYPE);
                    if (!in_raster) phase = PH_SKIP;
                end else if (pos >= 4 && pos <= 7) begin
                    if (pos == 4) hdr_sec = {24'h0, b};
                    else hdr_sec[8*(pos-4) +: 8] = b;
                end else if (pos >= 8 && pos <= 11) begin
                    if (pos == 8) hdr_frac = {24'h0, b};
                    else hdr_frac[8*(pos-8) +: 8] = b;
                end else if (pos == 16) begin
                    low_byte = b;
                end else if (pos == 17) begin
                    pulses_left = {b[6:0], low_byte};
                    digit       = b[7];
                    pulse_cnt   = '0;
                    start_pulse(32'd18);
                end
            end
            PH_PULSE: begin
                rel = pos - pulse_start;
                if (rel <= 2) begin
                    if (rel == 0) ticks = {16'h0, b};
                    else ticks[8*rel +: 8] = b;
                end else if (rel == 9) begin
                    angle = {8'h0, b};
                end else if (rel == 10) begin
                    angle[15:8] = b;
                end else if (rel == 11) begin
                    pword = {8'h0, b};
                end else if (rel == 12) begin
                    pword[15:8] = b;
                end else if (rel == 13) begin
                    plen = {8'h0, b};
                end else if (rel >= 14) begin
                    plen[15:8] = b;
                    e = longint'(pulse_start) + 14 + longint'(plen);
                    if (e > longint'(rec_len) - 1) e = longint'(rec_len) - 1;
                    pulse_end = e[23:0];
                    push_word(KIND_PULSE, 3'd0, 16'd0, 8'd0);
                    rx_chan = '0;
                    if (emit_waves &&
                        longint'(pulse_start) + PULSE_HDR_LEN <= longint'(pulse_end)) begin
                        phase = PH_TXLEN;
                    end else begin
                        phase = PH_PAD;
                    end
                    check_end = 1'b1;
                end
            end
            PH_TXLEN: begin
                wave_left = {8'h0, b};
                wave_idx  = '0;
                phase     = (b != 0) ? PH_TX : PH_PAD;
                check_end = 1'b1;
            end
            PH_TX: begin
                v = b;
                if (wave_idx == 0) first_tx = b;
                if (clean_idx != 0 && 32'(wave_idx) >= 32'(clean_idx) - 32'd1) v = first_tx;
                push_word(KIND_WAVE, 3'd0, wave_idx, v);
                wave_idx  = wave_idx + 1'b1;
                wave_left = wave_left - 1'b1;
                if (wave_left == 0) next_wave();
                check_end = 1'b1;
            end
            PH_RXLEN0: begin
                low_byte  = b;
                phase     = PH_RXLEN1;
                check_end = 1'b1;
            end
            PH_RXLEN1: begin
                len16 = {b, low_byte};
                if (len16 == 0 || longint'(pos) + longint'(len16) > longint'(pulse_end)) begin
                    phase = PH_PAD;
                end else begin
                    rx_chan   = rx_chan + 1'b1;
                    wave_left = len16;
                    wave_idx  = '0;
                    phase     = PH_RX;
                end
                check_end = 1'b1;
            end
            PH_RX: begin
                push_word(KIND_WAVE, rx_chan, wave_idx, b);
                wave_idx  = wave_idx + 1'b1;
                wave_left = wave_left - 1'b1;
                if (wave_left == 0) next_wave();
                check_end = 1'b1;
            end
            PH_PAD: check_end = 1'b1;
            default: ;
        endcase

        if (check_end && pos == pulse_end) start_pulse(32'(pos) + 32'd1);

        if (phase != PH_LEN && phase != PH_HALT && 32'(pos) == 32'(rec_len) - 32'd1)
            rec_done = 1'b1;

        if (rec_done) begin
            if (in_raster) n_raster++;
            if (in_raster && raster_cnt != 0) raster_cnt = raster_cnt + 1'b1;
            in_raster = 1'b0;
            phase     = PH_LEN;
            rec_pos   = '0;
        end else if (phase != PH_HALT) begin
            rec_pos = pos + 1'b1;
        end

        if (w.end_of_log) restart();
    endfunction

    function void show_diff(string name, logic [32:0] e, logic [32:0] a);
        if (e !== a) $display("  %-13s expected %0h got %0h", name, e, a);
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        if (parsed_words.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected output word %h", got);
            return;
        end
        want = parsed_words.pop_front();
        checked++;
        if (got !== want) begin
            fails++;
            if (fails <= 10) begin
                $display("output word %0d differs:", checked);
                show_diff("kind", want.kind, got.kind);
                show_diff("raster_number", want.raster_number, got.raster_number);
                show_diff("pulse_number", want.pulse_number, got.pulse_number);
                show_diff("digitizer", want.digitizer, got.digitizer);
                show_diff("seconds", want.seconds, got.seconds);
                show_diff("time_ticks", want.time_ticks, got.time_ticks);
                show_diff("beam_angle", $unsigned(want.beam_angle), $unsigned(got.beam_angle));
                show_diff("range_value", want.range_value, got.range_value);
                show_diff("dropout", want.dropout, got.dropout);
                show_diff("channel", want.channel, got.channel);
                show_diff("sample_index", want.sample_index, got.sample_index);
                show_diff("sample_value", want.sample_value, got.sample_value);
            end
        end
    endfunction

    function int pending();
        return parsed_words.size();
    endfunction
endclass

module testbench;
    localparam int RX_CH = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_word             in_data = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            o_out_data;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    record_parser_scoreboard #(RX_CH) sb;

    logic [7:0]  log_q[$];
    logic [7:0]  body_q[$];
    logic [7:0]  wave_q[$];
    int          burst_left = 0;
    int          sent_bytes = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned tick = 0;

    lidar_raster_record_parser #(
        .RX_CHANNELS(RX_CH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        tick <= tick + 1;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (tick % 4 == 0);
            default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_word(o_out_data);
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void body_le(int unsigned v, int n);
        int i;
        for (i = 0; i < n; i++) body_q.push_back(8'(v >> (8 * i)));
    endfunction

    function automatic void add_pulse();
        int txlen;
        int nrx;
        int len;
        int fill;
        int plen;
        int i;
        int k;
        wave_q.delete();
        case ($urandom_range(0, 29))
            0, 1:    txlen = 0;
            2:       txlen = $urandom_range(200, 255);
            default: txlen = $urandom_range(1, 8);
        endcase
        wave_q.push_back(8'(txlen));
        for (i = 0; i < txlen; i++) wave_q.push_back(rnd_byte());
        nrx = (txlen == 0) ? 0 : $urandom_range(0, RX_CH + 1);
        for (k = 0; k < nrx; k++) begin
            len  = $urandom_range(1, 6);
            fill = len;
            case ($urandom_range(0, 9))
                0: begin
                    len  = 0;
                    fill = 0;
                end
                1: len = len + $urandom_range(1, 40);
                2: len = 16'hFFFF;
                default: ;
            endcase
            wave_q.push_back(8'(len));
            wave_q.push_back(8'(len >> 8));
            for (i = 0; i < fill; i++) wave_q.push_back(rnd_byte());
        end
        fill = $urandom_range(0, 2);
        for (i = 0; i < fill; i++) wave_q.push_back(rnd_byte());
        plen = wave_q.size();
        case ($urandom_range(0, 11))
            0: plen = $urandom_range(0, plen);
            1: plen = plen + $urandom_range(1, 6);
            2: plen = 16'hFFFF;
            default: ;
        endcase
        body_le(($urandom_range(0, 7) == 0) ? 24'hFFFFFF : ($urandom & 24'hFFFFFF), 3);
        for (i = 0; i < 6; i++) body_q.push_back(rnd_byte());
        case ($urandom_range(0, 5))
            0: body_le(16'h8000, 2);
            1: body_le(16'h7FFF, 2);
            default: body_le($urandom, 2);
        endcase
        body_le($urandom, 2);
        body_le(plen, 2);
        for (i = 0; i < wave_q.size(); i++) body_q.push_back(wave_q[i]);
    endfunction

    // length field, then the body cut or padded to the claimed length
    function automatic void emit_record(int claim);
        int i;
        log_q.push_back(8'(claim));
        log_q.push_back(8'(claim >> 8));
        log_q.push_back(8'(claim >> 16));
        for (i = 0; i < claim - 3; i++)
            log_q.push_back((i < body_q.size()) ? body_q[i] : rnd_byte());
    endfunction

    function automatic void add_raster();
        int npulse;
        int count;
        int full;
        int claim;
        int i;
        body_q.delete();
        body_q.push_back(RASTER_TYPE);
        body_le(($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom, 4);
        body_le(($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom, 4);
        for (i = 0; i < 4; i++) body_q.push_back(rnd_byte());
        npulse = $urandom_range(0, 3);
        count  = npulse;
        case ($urandom_range(0, 9))
            0: count = npulse + 1;
            1: count = (npulse > 0) ? npulse - 1 : 0;
            2: count = 15'h7FFF;
            default: ;
        endcase
        body_le(($urandom_range(0, 1) << 15) | count, 2);
        for (i = 0; i < npulse; i++) add_pulse();
        full  = body_q.size() + 3;
        claim = full;
        case ($urandom_range(0, 7))
            0: claim = $urandom_range(18, full);
            1: claim = full + $urandom_range(1, 5);
            default: ;
        endcase
        emit_record(claim);
    endfunction

    function automatic void build_log();
        int nrec;
        int i;
        int cut;
        log_q.delete();
        if ($urandom_range(0, 11) == 0) begin
            nrec = $urandom_range(1, 8);
            for (i = 0; i < nrec; i++) log_q.push_back(8'($urandom));
            return;
        end
        nrec = $urandom_range(1, 3);
        for (i = 0; i < nrec; i++) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    body_q.delete();
                    cut = $urandom_range(0, 255);
                    body_q.push_back((cut == RASTER_TYPE) ? 8'd6 : 8'(cut));
                    emit_record($urandom_range(4, 24));
                end
                2: begin
                    body_q.delete();
                    body_q.push_back(RASTER_TYPE);
                    emit_record($urandom_range(4, 17));
                end
                3: begin
                    body_q.delete();
                    emit_record($urandom_range(1, 3));
                end
                default: add_raster();
            endcase
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(0, 3);
            log_q.push_back(8'h00);
            log_q.push_back(8'h00);
            log_q.push_back(8'h00);
            for (i = 0; i < cut; i++) log_q.push_back(rnd_byte());
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, log_q.size());
            while (log_q.size() > cut) void'(log_q.pop_back());
        end
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do begin
            @(negedge i_clk);
        end while (!o_in_ready);
        @(posedge i_clk);
        sb.parse_byte(w);
        sent_bytes++;
    endtask

    task automatic send_log();
        t_in_word w;
        int i;
        for (i = 0; i < log_q.size(); i++) begin
            w.data_byte  = log_q[i];
            w.end_of_log = (i == log_q.size() - 1);
            send_word(w);
        end
    endtask

    task automatic wait_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge i_clk);
        end while (!o_cfg_ready);
        @(posedge i_clk);
        sb.load_reg(idx, data);
    endtask

    task automatic set_regs(logic [31:0] start, logic emit, logic [7:0] clean);
        write_cfg(CFG_RASTER_START, start);
        write_cfg(CFG_EMIT_WAVEFORMS, {31'd0, emit});
        write_cfg(CFG_TX_CLEAN_INDEX, {24'd0, clean});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tiny records, a skipped type, a zero length halt with trailing bytes
        log_q = '{8'h01, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00,
                  8'h05, 8'h00, 8'h00, 8'h07, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA};
        send_log();
        log_q = '{8'h80};
        send_log();

        for (ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: set_regs(32'd1, 1'b1, 8'd0);
                    2: set_regs(32'hFFFF_FFFE, 1'b1, 8'd1);
                    3: set_regs($urandom, 1'b1, 8'($urandom_range(2, 12)));
                    4: set_regs(32'hFFFF_FFFF, 1'b0, 8'hFF);
                    5: set_regs(32'd0, 1'b1, 8'hFF);
                    6: set_regs($urandom, 1'b1, 8'd0);
                    default: set_regs($urandom, 1'($urandom_range(0, 1)), 8'($urandom));
                endcase
            end
            // running byte budget, at least one log per setting
            do begin
                build_log();
                send_log();
                if ($urandom_range(0, 4) == 0) wait_drained();
            end while (sent_bytes < 100 * (ph + 1));
        end
        wait_drained();

        $display("Sent %0d log bytes under 8 register settings, %0d raster records closed.",
                 sent_bytes, sb.n_raster);
        $display("Checked %0d pulse words and %0d waveform words, %0d mismatches.",
                 sb.n_pulse, sb.n_wave, sb.fails);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
